@@ rtl/core/eti_pkg.sv @@
// ----------------------------------------------------------------------------
// eti_pkg
// Shared types, constants and header builder for the Ethernet/IPv4 tunnel
// encapsulator and decapsulator.
// ----------------------------------------------------------------------------
package eti_pkg;

    // Size limits and header geometry.
    localparam int MAX_PAYLOAD  = 1472;
    localparam int HDR_BYTES    = 34;
    localparam int IP_HDR_BYTES = 20;

    // Request queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int LEN_W  = 11;
    localparam int POS_W  = 6;
    localparam int ADDR_W = 3;

    // Request kinds on the input channel.
    localparam logic KIND_OUTBOUND = 1'b0;
    localparam logic KIND_INBOUND  = 1'b1;

    // Result directions.
    localparam logic DIR_WIRE   = 1'b0;
    localparam logic DIR_TUNNEL = 1'b1;

    // Configuration register indexes (selected by paddr[2]).
    localparam logic REG_LOCAL = 1'b0;
    localparam logic REG_PEER  = 1'b1;

    // Fixed header contents.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] VER_IHL_TOS    = 16'h4500;
    localparam logic [15:0] TTL_PROTO      = 16'h32FF;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic             first;
        logic             last;
        logic [LEN_W-1:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic       direction;
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // One queued request: a byte to forward, optionally preceded by a header.
    typedef struct packed {
        logic             hdr;
        logic             direction;
        logic [7:0]       data_byte;
        logic             last;
        logic [LEN_W-1:0] total;
        logic [15:0]      csum;
    } q_entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Returns header byte idx of the outbound frame.
    function automatic logic [7:0] hdr_byte(
        input logic [POS_W-1:0] idx,
        input logic [LEN_W-1:0] total,
        input logic [15:0]      csum,
        input logic [31:0]      local_addr,
        input logic [31:0]      peer_addr
    );
        logic [15:0] total16;
        logic [7:0]  b;
        total16 = {{(16-LEN_W){1'b0}}, total};
        case (idx)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = 8'hFF;
            6'd6:  b = 8'h00;
            6'd7:  b = 8'hAA;
            6'd8:  b = 8'hBB;
            6'd9:  b = 8'hCC;
            6'd10: b = 8'hDD;
            6'd11: b = 8'hEE;
            6'd12: b = ETHERTYPE_IPV4[15:8];
            6'd13: b = ETHERTYPE_IPV4[7:0];
            6'd14: b = VER_IHL_TOS[15:8];
            6'd15: b = VER_IHL_TOS[7:0];
            6'd16: b = total16[15:8];
            6'd17: b = total16[7:0];
            6'd22: b = TTL_PROTO[15:8];
            6'd23: b = TTL_PROTO[7:0];
            6'd24: b = csum[15:8];
            6'd25: b = csum[7:0];
            6'd26: b = local_addr[31:24];
            6'd27: b = local_addr[23:16];
            6'd28: b = local_addr[15:8];
            6'd29: b = local_addr[7:0];
            6'd30: b = peer_addr[31:24];
            6'd31: b = peer_addr[23:16];
            6'd32: b = peer_addr[15:8];
            6'd33: b = peer_addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/eti_front.sv @@
// ----------------------------------------------------------------------------
// eti_front
// Accepts input requests, tracks and filters inbound frames, and queues the
// work for each outbound or forwarded inbound byte, with the header checksum.
// ----------------------------------------------------------------------------
module eti_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  eti_pkg::in_item_t s_item,
    input  logic [31:0]       local_address,
    input  logic [31:0]       peer_address,
    input  eti_pkg::q_status_t q_status,
    output logic              q_push,
    output eti_pkg::q_entry_t q_entry
);
    import eti_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             match_reg, match_next;
    logic             accept;
    logic [POS_W-1:0] pos_cur;
    logic             match_cur;
    logic             fwd_inbound;
    logic [LEN_W-1:0] plen_sat;
    logic [LEN_W-1:0] total;
    logic [18:0]      sum;
    logic [16:0]      fold1;
    logic [15:0]      fold2;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // Inbound frame tracking: offset and running match of the header checks.
    always_comb begin
        pos_cur   = s_item.first ? '0 : pos_reg;
        match_cur = s_item.first ? 1'b1 : match_reg;
        if (pos_cur == POS_W'(12) && s_item.data_byte != ETHERTYPE_IPV4[15:8]) begin
            match_cur = 1'b0;
        end
        if (pos_cur == POS_W'(13) && s_item.data_byte != ETHERTYPE_IPV4[7:0]) begin
            match_cur = 1'b0;
        end
        if (pos_cur == POS_W'(30) && s_item.data_byte != local_address[31:24]) begin
            match_cur = 1'b0;
        end
        if (pos_cur == POS_W'(31) && s_item.data_byte != local_address[23:16]) begin
            match_cur = 1'b0;
        end
        if (pos_cur == POS_W'(32) && s_item.data_byte != local_address[15:8]) begin
            match_cur = 1'b0;
        end
        if (pos_cur == POS_W'(33) && s_item.data_byte != local_address[7:0]) begin
            match_cur = 1'b0;
        end
        fwd_inbound = (pos_cur >= POS_W'(HDR_BYTES)) && match_cur;

        pos_next   = pos_reg;
        match_next = match_reg;
        if (accept && s_item.kind == KIND_INBOUND) begin
            if (s_item.last) begin
                pos_next   = '0;
                match_next = 1'b1;
            end else begin
                pos_next   = (pos_cur < POS_W'(HDR_BYTES)) ? pos_cur + POS_W'(1) : pos_cur;
                match_next = match_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            match_reg <= 1'b1;
        end else begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
        end
    end

    // Outbound header length and ones'-complement checksum.
    always_comb begin
        plen_sat = (s_item.payload_length > LEN_W'(MAX_PAYLOAD)) ?
                   LEN_W'(MAX_PAYLOAD) : s_item.payload_length;
        total = plen_sat + LEN_W'(IP_HDR_BYTES);
        sum = 19'(VER_IHL_TOS) + 19'(total) + 19'(TTL_PROTO)
            + 19'(local_address[31:16]) + 19'(local_address[15:0])
            + 19'(peer_address[31:16]) + 19'(peer_address[15:0]);
        fold1 = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
        fold2 = fold1[15:0] + {15'b0, fold1[16]};
    end

    // Queue entry for the accepted request.
    always_comb begin
        q_entry.hdr       = (s_item.kind == KIND_OUTBOUND) && s_item.first;
        q_entry.direction = (s_item.kind == KIND_OUTBOUND) ? DIR_WIRE : DIR_TUNNEL;
        q_entry.data_byte = s_item.data_byte;
        q_entry.last      = s_item.last;
        q_entry.total     = total;
        q_entry.csum      = ~fold2;
        q_push = accept && ((s_item.kind == KIND_OUTBOUND) || fwd_inbound);
    end

endmodule

@@ rtl/core/eti_queue.sv @@
// ----------------------------------------------------------------------------
// eti_queue
// Short first-in first-out queue of requests between the front and back parts.
// ----------------------------------------------------------------------------
module eti_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  eti_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output eti_pkg::q_entry_t  head,
    output eti_pkg::q_status_t status
);
    import eti_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/eti_back.sv @@
// ----------------------------------------------------------------------------
// eti_back
// Drains queued requests, emitting header bytes then the carried byte into
// an output register, one result per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module eti_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  eti_pkg::q_entry_t  head,
    input  eti_pkg::q_status_t q_status,
    output logic               pop,
    input  logic [31:0]        local_address,
    input  logic [31:0]        peer_address,
    output logic               m_valid,
    input  logic               m_ready,
    output eti_pkg::out_item_t m_item
);
    import eti_pkg::*;

    logic             valid_reg, valid_next;
    out_item_t        item_reg, item_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic             load;

    assign m_valid = valid_reg;
    assign m_item  = item_reg;
    assign load    = !valid_reg || m_ready;

    // Pick the next result byte: a header byte while one is due, else the data.
    always_comb begin
        valid_next = valid_reg && !m_ready;
        item_next  = item_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load && !q_status.empty) begin
            valid_next          = 1'b1;
            item_next.direction = head.direction;
            if (head.hdr && idx_reg < POS_W'(HDR_BYTES)) begin
                item_next.out_byte = hdr_byte(idx_reg, head.total, head.csum,
                                              local_address, peer_address);
                item_next.out_last = 1'b0;
                idx_next           = idx_reg + POS_W'(1);
            end else begin
                item_next.out_byte = head.data_byte;
                item_next.out_last = head.last;
                idx_next           = '0;
                pop                = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

@@ rtl/core/eth_ipv4_tunnel_encap_decap.sv @@
// ----------------------------------------------------------------------------
// eth_ipv4_tunnel_encap_decap
// Byte-stream Ethernet/IPv4 tunnel encapsulator and decapsulator.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle while s_ready is high and emits
// at most one result byte per cycle from a registered output. An outbound
// first byte turns into 35 result bytes (the 34-byte header, then the byte);
// every other outbound byte and every forwarded inbound byte yields one
// result byte, and a dropped inbound byte yields none. A four-entry request
// queue between the input side and the output side lets input keep flowing
// during a header burst until it fills; the sustained rate is therefore set
// by the output register, one result byte per cycle while m_ready is high.
// An accepted request is written to the queue, then loaded into the output
// register. Local and peer addresses sit on an APB port at byte addresses 0
// and 4 and must only be changed while no traffic is in flight.
module eth_ipv4_tunnel_encap_decap (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  eti_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output eti_pkg::out_item_t  m_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [eti_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import eti_pkg::*;

    logic [31:0] local_reg, local_next;
    logic [31:0] peer_reg, peer_next;
    logic        cfg_write;
    logic        q_push;
    logic        q_pop;
    q_entry_t    q_in;
    q_entry_t    q_head;
    q_status_t   q_status;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_PEER) ? peer_reg : local_reg;

    always_comb begin
        local_next = local_reg;
        peer_next  = peer_reg;
        if (cfg_write) begin
            if (paddr[2] == REG_LOCAL) begin
                local_next = pwdata;
            end else begin
                peer_next = pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_reg <= 32'hC0A8_FF01;
            peer_reg  <= 32'hC0A8_FF0A;
        end else begin
            local_reg <= local_next;
            peer_reg  <= peer_next;
        end
    end

    // Front part: acceptance, inbound filtering, header preparation.
    eti_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .local_address (local_reg),
        .peer_address  (peer_reg),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    // Request queue.
    eti_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    // Back part: header and byte emission.
    eti_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .q_status      (q_status),
        .pop           (q_pop),
        .local_address (local_reg),
        .peer_address  (peer_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item)
    );

    // The queue is never written while full.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !q_push)
        else $error("request queue written while full");

    // The queue is never read while empty.
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !q_pop)
        else $error("request queue read while empty");

    // Every accepted outbound byte produces a queued request.
    a_outbound_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.kind == KIND_OUTBOUND) |-> q_push)
        else $error("outbound request lost");

endmodule
